### rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that prop holds at every rising edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that cond in one cycle implies cons in the next
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ras_pkg.sv
package ras_pkg;

  localparam int unsigned OperandBits = 16;
  localparam int unsigned MagBits     = 2 * OperandBits + 1;
  localparam int unsigned CntBits     = $clog2(MagBits + 1);
  localparam int unsigned NumBits     = 33;
  localparam int unsigned DenBits     = 32;

  typedef logic [MagBits-1:0] mag_t;

  // Divider operation select
  typedef enum logic [1:0] {
    DivEuclid = 2'd0,
    DivNum    = 2'd1,
    DivDen    = 2'd2
  } div_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     euclid_step;
    logic     out_load;
    logic     out_zero;
  } ras_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic all_zero;
    logic y_zero;
    logic div_done;
  } ras_sts_t;

endpackage

### rtl/ras_if.sv
interface ras_in_if;
  import ras_pkg::*;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic signed [OperandBits-1:0] a_num;
  logic signed [OperandBits-1:0] a_den;
  logic signed [OperandBits-1:0] b_num;
  logic signed [OperandBits-1:0] b_den;
  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface ras_out_if;
  import ras_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [NumBits-1:0] res_num;
  logic signed [DenBits-1:0] res_den;
  logic                      zero_divisor;
  modport source (output valid, res_num, res_den, zero_divisor, input ready);
  modport sink   (input valid, res_num, res_den, zero_divisor, output ready);
endinterface

### rtl/rational_add_subtract_top.sv
// rational_add_subtract_top: a/b +/- c/d, reduced by a gcd from Euclid's loop.
// Input channel in_if carries opcode (0 add, 1 subtract) and two 16-bit signed
// fractions; output channel out_if returns res_num, res_den and zero_divisor.
// Both are valid/ready; an item moves when valid and ready are high at an edge.
// Products are formed combinationally and registered at load. The gcd then
// runs on one shared restoring divider of 33 bits, one quotient bit a cycle, a
// division per remainder step, followed by two divisions for the reduced
// numerator and denominator. One item is in work at a time.
// When both raw terms are zero the result is 0/0 with zero_divisor set.
// The result stays in an output register until taken; the block accepts the
// next item meanwhile and, if the register is still held, stalls before its
// last division (or before loading a zero-divisor result) until it is taken.
// Reset (rst_ni low) empties the block; no result is pending.
module rational_add_subtract_top
  import ras_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  ras_in_if.sink   in_if,
  ras_out_if.source out_if
);

  ras_cmd_t cmd;
  ras_sts_t sts;

  ras_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ras_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_if  (in_if),
    .num_o  (out_if.res_num),
    .den_o  (out_if.res_den),
    .zdiv_o (out_if.zero_divisor)
  );

endmodule

### rtl/ras_divider.sv
`include "assert_macros.svh"

module ras_divider
  import ras_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  mag_t dividend_i,
  input  mag_t divisor_i,
  output logic done_o,
  output mag_t quot_o,
  output mag_t rem_o
);

  logic              busy_q, busy_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  mag_t              quot_q, quot_d;
  mag_t              rem_q, rem_d;
  mag_t              dvs_q, dvs_d;
  logic [MagBits:0]  trial;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quot_q[MagBits-1]} - {1'b0, dvs_q};
    done_o = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(MagBits);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[MagBits]) begin
        rem_d = trial[MagBits-1:0];
      end else begin
        rem_d = {rem_q[MagBits-2:0], quot_q[MagBits-1]};
      end
      quot_d = {quot_q[MagBits-2:0], ~trial[MagBits]};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign quot_o = quot_d;
  assign rem_o  = rem_d;

  `ASSERT_ALWAYS(a_cnt_busy, (cnt_q != '0) == busy_q, "divider count out of step")
  `ASSERT_NEXT(a_start_busy, start_i, busy_q, "divider not busy after start")

endmodule

### rtl/ras_datapath.sv
module ras_datapath
  import ras_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ras_cmd_t cmd_i,
  output ras_sts_t sts_o,
  ras_in_if.sink   in_if,
  output logic signed [NumBits-1:0] num_o,
  output logic signed [DenBits-1:0] den_o,
  output logic     zdiv_o
);

  localparam int unsigned PB = 2 * OperandBits;

  logic [OperandBits-1:0] an_m, ad_m, bn_m, bd_m;
  logic [PB-1:0]          p_m, q_m, d_m;
  logic                   p_s, q_s, d_s;
  mag_t                   n_mag_q, d_mag_q, x_q, y_q, rn_q;
  logic                   n_neg_q, d_neg_q, odd_q, rn_neg;
  mag_t                   sum_m;
  logic                   sum_s;
  mag_t                   dvd, dvs, quot, rem;
  logic                   done, g_neg;
  logic                   nn_d, dn_d;

  function automatic logic [OperandBits-1:0] mag_of(input logic [OperandBits-1:0] v);
    return v[OperandBits-1] ? (~v + 1'b1) : v;
  endfunction

  // Operand products, registered once at load
  always_comb begin
    an_m = mag_of(in_if.a_num);
    ad_m = mag_of(in_if.a_den);
    bn_m = mag_of(in_if.b_num);
    bd_m = mag_of(in_if.b_den);
    p_m  = an_m * bd_m;
    q_m  = bn_m * ad_m;
    d_m  = ad_m * bd_m;
    p_s  = (p_m != '0) && (in_if.a_num[OperandBits-1] ^ in_if.b_den[OperandBits-1]);
    q_s  = (q_m != '0) && (in_if.b_num[OperandBits-1] ^ in_if.a_den[OperandBits-1] ^
           in_if.opcode);
    d_s  = (d_m != '0) && (in_if.a_den[OperandBits-1] ^ in_if.b_den[OperandBits-1]);
    if (p_s == q_s) begin
      sum_m = MagBits'(p_m) + MagBits'(q_m);
      sum_s = p_s;
    end else if (p_m >= q_m) begin
      sum_m = MagBits'(p_m - q_m);
      sum_s = p_s;
    end else begin
      sum_m = MagBits'(q_m - p_m);
      sum_s = q_s;
    end
    nn_d = sum_s && (sum_m != '0);
    dn_d = d_s;
  end

  always_comb begin
    unique case (cmd_i.div_sel)
      DivNum:  dvd = n_mag_q;
      DivDen:  dvd = d_mag_q;
      default: dvd = x_q;
    endcase
    dvs = (cmd_i.div_sel == DivEuclid) ? y_q : x_q;
  end

  ras_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign g_neg  = odd_q ? d_neg_q : n_neg_q;
  assign rn_neg = (quot != '0) && (d_neg_q ^ g_neg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q <= 1'b0;
    end else if (cmd_i.load) begin
      odd_q <= 1'b0;
    end else if (cmd_i.euclid_step) begin
      odd_q <= ~odd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_mag_q <= sum_m;
      n_neg_q <= nn_d;
      d_mag_q <= MagBits'(d_m);
      d_neg_q <= dn_d;
      x_q     <= sum_m;
      y_q     <= MagBits'(d_m);
    end else if (cmd_i.euclid_step) begin
      x_q <= y_q;
      y_q <= rem;
    end
    // Numerator quotient is held until the denominator one completes
    if (done && cmd_i.div_sel == DivNum) begin
      rn_q <= (quot != '0) && (n_neg_q ^ g_neg) ? -quot : quot;
    end
    if (cmd_i.out_load) begin
      num_o  <= cmd_i.out_zero ? '0 : NumBits'(rn_q);
      den_o  <= cmd_i.out_zero ? '0 : DenBits'(rn_neg ? -quot : quot);
      zdiv_o <= cmd_i.out_zero;
    end
  end

  assign sts_o.all_zero = (n_mag_q == '0) && (d_mag_q == '0);
  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.div_done = done;

endmodule

### rtl/ras_ctrl.sv
`include "assert_macros.svh"

module ras_ctrl
  import ras_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ras_sts_t sts_i,
  output ras_cmd_t cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;
  localparam logic [2:0] SEuc   = 3'd2;
  localparam logic [2:0] SNum   = 3'd3;
  localparam logic [2:0] SDen   = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       busy_q, busy_d;
  logic       ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    cmd_o.div_sel = DivEuclid;
    in_ready_o = (state_q == SIdle);
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = SCheck;
        end
      end
      SCheck: begin
        if (sts_i.all_zero) begin
          if (!ov_d) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_zero = 1'b1;
            ov_d = 1'b1;
            state_d = SIdle;
          end
        end else if (sts_i.y_zero) begin
          cmd_o.div_sel = DivNum;
          cmd_o.div_start = 1'b1;
          state_d = SNum;
        end else begin
          cmd_o.div_start = 1'b1;
          busy_d = 1'b1;
          state_d = SEuc;
        end
      end
      SEuc: begin
        if (busy_q) begin
          if (sts_i.div_done) begin
            cmd_o.euclid_step = 1'b1;
            busy_d = 1'b0;
          end
        end else if (sts_i.y_zero) begin
          cmd_o.div_sel = DivNum;
          cmd_o.div_start = 1'b1;
          state_d = SNum;
        end else begin
          cmd_o.div_start = 1'b1;
          busy_d = 1'b1;
        end
      end
      SNum: begin
        cmd_o.div_sel = DivNum;
        if (sts_i.div_done) state_d = SDen;
      end
      SDen: begin
        cmd_o.div_sel = DivDen;
        // Hold the last division until the output register is free
        if (!ov_d) begin
          cmd_o.div_start = 1'b1;
          state_d = SOut;
        end
      end
      SOut: begin
        cmd_o.div_sel = DivDen;
        if (sts_i.div_done) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      busy_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

  `ASSERT_NEXT(a_load_check, cmd_o.load, state_q == SCheck, "load did not enter check")
  `ASSERT_ALWAYS(a_no_overwrite, !(cmd_o.out_load && ov_q && !out_ready_i),
                 "result overwritten while held")
  `ASSERT_ALWAYS(a_ready_idle, !(in_ready_o && busy_q && state_q != SIdle),
                 "ready while working")

endmodule

### sim/testbench.sv
module testbench;
  import ras_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                          opcode;
    logic signed [OperandBits-1:0] a_num;
    logic signed [OperandBits-1:0] a_den;
    logic signed [OperandBits-1:0] b_num;
    logic signed [OperandBits-1:0] b_den;
  } frac_pair_t;

  typedef struct {
    logic [NumBits-1:0] res_num;
    logic [DenBits-1:0] res_den;
    logic               zero_divisor;
  } reduced_t;

  localparam logic OpAdd = 1'b0;
  localparam logic OpSub = 1'b1;
  localparam int   CycleLimit = 10000000;
  localparam int   DrainCycles = 2000;

  logic clk_i;
  logic rst_ni;

  ras_in_if  in_if ();
  ras_out_if out_if ();

  rational_add_subtract_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  frac_pair_t pending_q[$];
  reduced_t   reduced_q[$];
  int         error_count;
  int         cycle_count;
  bit         hold_sender;
  int         burst_left;
  int         gap_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sign-magnitude helpers at 64-bit working precision
  function automatic void split(input logic signed [OperandBits-1:0] v,
                                output bit neg, output longint unsigned mag);
    neg = v[OperandBits-1];
    mag = neg ? longint'(-longint'(v)) : longint'(v);
  endfunction

  function automatic void sm_add(input bit xn, input longint unsigned xm,
                                 input bit yn, input longint unsigned ym,
                                 output bit rn, output longint unsigned rm);
    if (xn == yn) begin
      rm = xm + ym;
      rn = xn;
    end else if (xm >= ym) begin
      rm = xm - ym;
      rn = xn;
    end else begin
      rm = ym - xm;
      rn = yn;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  function automatic reduced_t reduce_sum(input frac_pair_t it);
    reduced_t        r;
    bit              an, ad, bn, bd, pn, qn, nn, dn, gn, odd;
    longint unsigned am, adm, bm, bdm, pm, qm, nm, dm, x, y, t, rnm, rdm;
    split(it.a_num, an, am);
    split(it.a_den, ad, adm);
    split(it.b_num, bn, bm);
    split(it.b_den, bd, bdm);
    pm = am * bdm;
    pn = (pm != 0) && (an != bd);
    qm = bm * adm;
    qn = (qm != 0) && (bn != ad);
    if (it.opcode == OpSub) qn = (qm != 0) && !qn;
    sm_add(pn, pm, qn, qm, nn, nm);
    dm = adm * bdm;
    dn = (dm != 0) && (ad != bd);
    r = '{default: '0};
    if (nm == 0 && dm == 0) begin
      r.zero_divisor = 1'b1;
      return r;
    end
    x = nm;
    y = dm;
    odd = 1'b0;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
      odd = ~odd;
    end
    gn = odd ? dn : nn;
    rnm = nm / x;
    rdm = dm / x;
    r.res_num = NumBits'(((rnm != 0) && (nn != gn)) ? -rnm : rnm);
    r.res_den = DenBits'(((rdm != 0) && (dn != gn)) ? -rdm : rdm);
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic logic signed [OperandBits-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 6)) - 3);
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push(input logic op, input int an, input int ad, input int bn, input int bd);
    pending_q.push_back('{op, 16'(an), 16'(ad), 16'(bn), 16'(bd)});
  endtask

  // Sender: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.opcode <= 1'b0;
      in_if.a_num  <= '0;
      in_if.a_den  <= '0;
      in_if.b_num  <= '0;
      in_if.b_den  <= '0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        reduced_q.push_back(reduce_sum(pending_q.pop_front()));
      end
      if (in_if.valid && !in_if.ready) begin
        // hold item until taken
      end else if (gap_left > 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() > (in_if.valid && in_if.ready ? 0 : 0) &&
                   !hold_sender && pending_q.size() != 0) begin
        in_if.valid  <= 1'b1;
        in_if.opcode <= pending_q[0].opcode;
        in_if.a_num  <= pending_q[0].a_num;
        in_if.a_den  <= pending_q[0].a_den;
        in_if.b_num  <= pending_q[0].b_num;
        in_if.b_den  <= pending_q[0].b_den;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 4);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3000);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern and check
  always @(posedge clk_i or negedge rst_ni) begin
    reduced_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (reduced_q.size() == 0) begin
          report("unexpected result", 64'(out_if.res_num), 64'(0));
        end else begin
          want = reduced_q.pop_front();
          if (out_if.res_num !== want.res_num)
            report("res_num", 64'(out_if.res_num), 64'(want.res_num));
          if (out_if.res_den !== want.res_den)
            report("res_den", 64'(out_if.res_den), 64'(want.res_den));
          if (out_if.zero_divisor !== want.zero_divisor)
            report("zero_divisor", 64'(out_if.zero_divisor), 64'(want.zero_divisor));
        end
      end
      case (cycle_count[13:12])
        2'd0: out_if.ready <= 1'b1;
        2'd1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_if.ready <= (cycle_count[9:0] > 10'd700);
        default: out_if.ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int mag;
    hold_sender = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    push(OpAdd, 1, 2, 1, 3);
    push(OpSub, 1, 2, 1, 3);
    push(OpAdd, 0, 0, 0, 0);
    push(OpSub, 5, 0, 3, 7);
    push(OpAdd, 0, 4, 0, 9);
    push(OpSub, 3, 4, 3, 4);
    push(OpAdd, -32768, -32768, -32768, -32768);
    push(OpSub, -32768, 32767, 32767, -32768);
    push(OpAdd, 32767, 32767, 32767, 32767);
    push(OpSub, -32768, 1, 32767, 1);
    push(OpAdd, 3, -4, 5, 6);
    push(OpSub, -7, 3, 2, -9);
    push(OpAdd, 1, 0, 1, 0);
    push(OpAdd, 0, 0, 5, 3);
    push(OpSub, -1, -1, -1, 1);
    push(OpAdd, 21, 34, 13, 55);
    push(OpAdd, 17711, 28657, 10946, 17711);
    push(OpSub, 65535, 65535, 0, 1);

    // Wait for all results before random traffic
    wait (pending_q.size() == 0);
    hold_sender = 1'b1;
    wait (reduced_q.size() == 0 && !in_if.valid);
    hold_sender = 1'b0;

    repeat (370) begin
      pending_q.push_back('{1'($urandom), rand_operand(), rand_operand(),
                            rand_operand(), rand_operand()});
      if ($urandom_range(0, 15) == 0) begin
        mag = $urandom_range(0, 5);
        push(1'($urandom), mag, 0, -mag, 0);
      end
    end

    wait (pending_q.size() == 0);
    @(posedge clk_i);
    wait (!in_if.valid && reduced_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && reduced_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
